### hw/rtl/touch_slider_event_filter_unit_defines.svh
// Assertion helpers shared by the filter RTL.
// Both expect clk and rst_n in scope (synchronous, active-low reset).
`ifndef TOUCH_SLIDER_EVENT_FILTER_UNIT_DEFINES_SVH
`define TOUCH_SLIDER_EVENT_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TSEF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsef assertion failed");

// Next-cycle implication.
`define TSEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsef assertion failed");

`endif

### hw/rtl/tsef_pkg.sv
`default_nettype none

package tsef_pkg;

  localparam int unsigned NUM_OF_CFG_REGS = 7;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  // Opcodes of an input item
  localparam logic [1:0] OP_EVENT  = 2'd0;
  localparam logic [1:0] OP_DRAIN  = 2'd1;
  localparam logic [1:0] OP_RESYNC = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SYNC         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_KEY          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ABSOLUTE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_REPORT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_DROPPED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_AXIS_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_TOUCH_BUTTON = 3'd6;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] RST_TYPE_SYNC         = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_TYPE_KEY          = 16'd1;
  localparam logic [CFG_DATA_W-1:0] RST_TYPE_ABSOLUTE     = 16'd3;
  localparam logic [CFG_DATA_W-1:0] RST_CODE_REPORT       = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_CODE_DROPPED      = 16'd3;
  localparam logic [CFG_DATA_W-1:0] RST_CODE_AXIS_X       = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_CODE_TOUCH_BUTTON = 16'd330;

  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_MOVED    = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_DROPPED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] type_sync;
    logic [CFG_DATA_W-1:0] type_key;
    logic [CFG_DATA_W-1:0] type_absolute;
    logic [CFG_DATA_W-1:0] code_report;
    logic [CFG_DATA_W-1:0] code_dropped;
    logic [CFG_DATA_W-1:0] code_axis_x;
    logic [CFG_DATA_W-1:0] code_touch_button;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic signed [31:0] resync_position;
    logic               resync_contact;
  } item_t;

  // Up to two results of one item; both carry the same position
  typedef struct packed {
    logic [1:0]         count;
    kind_t              kind0;
    kind_t              kind1;
    logic signed [31:0] position;
  } res_pair_t;

  // One entry of the result buffer
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] position;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/tsef_core.sv
`default_nettype none

`include "touch_slider_event_filter_unit_defines.svh"

// Frame/contact state and the per-item decision logic.
module tsef_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tsef_pkg::cfg_t     cfg,
  input  wire logic               fire,
  input  wire tsef_pkg::item_t    item,
  output tsef_pkg::res_pair_t     res
);
  import tsef_pkg::*;

  logic               discarding_r, discarding_nxt;
  logic               fhp_r, fhp_nxt;       // frame has position
  logic signed [31:0] fpos_r, fpos_nxt;     // frame position
  logic               fhb_r, fhb_nxt;       // frame has button
  logic               fbtn1_r, fbtn1_nxt;   // held button value is exactly 1
  logic               fbtn0_r, fbtn0_nxt;   // held button value is exactly 0
  logic signed [31:0] cur_r, cur_nxt;
  logic               contact_r, contact_nxt;
  logic               mp_r, mp_nxt;         // move pending

  logic is_pos, is_btn, is_drop, is_report;
  logic press, rel, c1, m1;

  assign is_pos    = (item.event_type == cfg.type_absolute) &&
                     (item.event_code == cfg.code_axis_x);
  assign is_btn    = (item.event_type == cfg.type_key) &&
                     (item.event_code == cfg.code_touch_button);
  assign is_drop   = (item.event_type == cfg.type_sync) &&
                     (item.event_code == cfg.code_dropped);
  assign is_report = (item.event_type == cfg.type_sync) &&
                     (item.event_code == cfg.code_report);

  // Commit of the held frame
  assign press = fhb_r && fbtn1_r && !contact_r;
  assign c1    = press ? 1'b1 : contact_r;
  assign m1    = press ? 1'b0 : ((fhp_r && contact_r) ? 1'b1 : mp_r);
  assign rel   = fhb_r && fbtn0_r && c1;

  always_comb begin
    discarding_nxt = discarding_r;
    fhp_nxt        = fhp_r;
    fpos_nxt       = fpos_r;
    fhb_nxt        = fhb_r;
    fbtn1_nxt      = fbtn1_r;
    fbtn0_nxt      = fbtn0_r;
    cur_nxt        = cur_r;
    contact_nxt    = contact_r;
    mp_nxt         = mp_r;
    res.count      = 2'd0;
    res.kind0      = KIND_PRESSED;
    res.kind1      = KIND_PRESSED;

    case (item.opcode)
      OP_EVENT: begin
        if (discarding_r) begin
          if (is_report) begin
            discarding_nxt = 1'b0;
            fhp_nxt        = 1'b0;
            fhb_nxt        = 1'b0;
          end
        end else if (is_pos) begin
          fhp_nxt  = 1'b1;
          fpos_nxt = item.event_value;
        end else if (is_btn) begin
          fhb_nxt   = 1'b1;
          fbtn1_nxt = (item.event_value == 32'sd1);
          fbtn0_nxt = (item.event_value == 32'sd0);
        end else if (is_drop) begin
          discarding_nxt = 1'b1;
          mp_nxt         = 1'b0;
          fhp_nxt        = 1'b0;
          fhb_nxt        = 1'b0;
          res.count      = 2'd1;
          res.kind0      = KIND_DROPPED;
        end else if (is_report) begin
          if (fhp_r) begin
            cur_nxt = fpos_r;
          end
          contact_nxt = c1;
          mp_nxt      = m1;
          if (press) begin
            res.count = 2'd1;
            res.kind0 = KIND_PRESSED;
          end
          if (rel) begin
            contact_nxt = 1'b0;
            mp_nxt      = 1'b0;
            if (m1) begin
              res.count = 2'd2;
              res.kind0 = KIND_MOVED;
              res.kind1 = KIND_RELEASED;
            end else begin
              res.count = 2'd1;
              res.kind0 = KIND_RELEASED;
            end
          end
          fhp_nxt = 1'b0;
          fhb_nxt = 1'b0;
        end
      end
      OP_DRAIN: begin
        if (mp_r) begin
          res.count = 2'd1;
          res.kind0 = KIND_MOVED;
          mp_nxt    = 1'b0;
        end
      end
      OP_RESYNC: begin
        cur_nxt        = item.resync_position;
        contact_nxt    = item.resync_contact;
        mp_nxt         = 1'b0;
        discarding_nxt = 1'b0;
        fhp_nxt        = 1'b0;
        fhb_nxt        = 1'b0;
      end
      default: begin
      end
    endcase

    // Every notification reports the position as it stands after the item
    res.position = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discarding_r <= 1'b0;
      fhp_r        <= 1'b0;
      fhb_r        <= 1'b0;
      fbtn1_r      <= 1'b0;
      fbtn0_r      <= 1'b0;
      cur_r        <= '0;
      contact_r    <= 1'b0;
      mp_r         <= 1'b0;
    end else if (fire) begin
      discarding_r <= discarding_nxt;
      fhp_r        <= fhp_nxt;
      fhb_r        <= fhb_nxt;
      fbtn1_r      <= fbtn1_nxt;
      fbtn0_r      <= fbtn0_nxt;
      cur_r        <= cur_nxt;
      contact_r    <= contact_nxt;
      mp_r         <= mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fpos_r <= fpos_nxt;
    end
  end

  `TSEF_ASSERT_NEXT(a_drop_sets_discard,
    fire && res.count != 2'd0 && res.kind0 == KIND_DROPPED, discarding_r)
  `TSEF_ASSERT_IMPLY(a_pair_is_move_release,
    fire && res.count == 2'd2, res.kind0 == KIND_MOVED && res.kind1 == KIND_RELEASED)
  `TSEF_ASSERT_NEXT(a_resync_clears,
    fire && item.opcode == OP_RESYNC, !discarding_r && !mp_r && !fhp_r && !fhb_r)

endmodule

`default_nettype wire

### hw/rtl/touch_slider_event_filter_unit.sv
// Channel  Handshake                  Payload
// in       in_valid / in_ready        opcode, event_type, event_code, event_value,
//                                     resync_position, resync_contact
// out      out_valid / out_ready      kind, position, last
// cfg      cfg_wr_en (no wait)        cfg_index, cfg_wr_data
//
// An accepted item is held in the input register, then is decided in a
// single pass and its 0..2 results land in a two-entry result buffer.
// Items flow one per cycle while out_ready is high and each gives at most one
// result; an item with two results (moved + released) holds the next one back.
// The first result is presented from buffer entry 0 once the item is decided.
// Reset (rst_n low, synchronous) clears control state and loads default config.
// A stalled result (out_ready low) stops decisions but the input register
// still fills, so one more item is taken while the result waits.

`default_nettype none

`include "touch_slider_event_filter_unit_defines.svh"

module touch_slider_event_filter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [15:0]                       in_event_type,
  input  wire logic [15:0]                       in_event_code,
  input  wire logic signed [31:0]                in_event_value,
  input  wire logic signed [31:0]                in_resync_position,
  input  wire logic                              in_resync_contact,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_kind,
  output logic signed [31:0]                     out_position,
  output logic                                   out_last,
  // configuration writes
  input  wire logic                              cfg_wr_en,
  input  wire logic [tsef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsef_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import tsef_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_sync         <= RST_TYPE_SYNC;
      cfg_r.type_key          <= RST_TYPE_KEY;
      cfg_r.type_absolute     <= RST_TYPE_ABSOLUTE;
      cfg_r.code_report       <= RST_CODE_REPORT;
      cfg_r.code_dropped      <= RST_CODE_DROPPED;
      cfg_r.code_axis_x       <= RST_CODE_AXIS_X;
      cfg_r.code_touch_button <= RST_CODE_TOUCH_BUTTON;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TYPE_SYNC:         cfg_r.type_sync         <= cfg_wr_data;
        CFG_TYPE_KEY:          cfg_r.type_key          <= cfg_wr_data;
        CFG_TYPE_ABSOLUTE:     cfg_r.type_absolute     <= cfg_wr_data;
        CFG_CODE_REPORT:       cfg_r.code_report       <= cfg_wr_data;
        CFG_CODE_DROPPED:      cfg_r.code_dropped      <= cfg_wr_data;
        CFG_CODE_AXIS_X:       cfg_r.code_axis_x       <= cfg_wr_data;
        CFG_CODE_TOUCH_BUTTON: cfg_r.code_touch_button <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------- input register ----------------
  logic  in_v_r;
  item_t item_r;
  logic  proc_fire;
  logic  buf_room;

  // Result buffer: count and two entries, head in entry 0
  logic [1:0] cnt_r;
  res_t       e0_r, e1_r;
  logic       pop;

  res_pair_t  res;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  // Decide an item only when both of its possible results fit. With one
  // entry left that is leaving now, the buffer is effectively empty.
  assign buf_room  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign proc_fire = in_v_r && buf_room;
  assign in_ready  = !in_v_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.opcode          <= in_opcode;
      item_r.event_type      <= in_event_type;
      item_r.event_code      <= in_event_code;
      item_r.event_value     <= in_event_value;
      item_r.resync_position <= in_resync_position;
      item_r.resync_contact  <= in_resync_contact;
    end
  end

  // ---------------- decision logic and state ----------------
  tsef_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (proc_fire),
    .item  (item_r),
    .res   (res)
  );

  // ---------------- result buffer ----------------
  // A decision always finds the buffer empty after this cycle's pop, so new
  // results are written from entry 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (proc_fire) begin
      cnt_r <= res.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      e0_r.kind     <= res.kind0;
      e0_r.position <= res.position;
      e0_r.last     <= (res.count == 2'd1);
      e1_r.kind     <= res.kind1;
      e1_r.position <= res.position;
      e1_r.last     <= 1'b1;
    end else if (pop) begin
      e0_r <= e1_r;
    end
  end

  assign out_kind     = e0_r.kind;
  assign out_position = e0_r.position;
  assign out_last     = e0_r.last;

  `TSEF_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r != 2'd3)
  `TSEF_ASSERT_IMPLY(a_fire_has_room,
    proc_fire, (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))
  `TSEF_ASSERT_IMPLY(a_pair_order,
    cnt_r == 2'd2, !e0_r.last && e1_r.last)

endmodule

`default_nettype wire
